### src/pss_pkg.sv
// Package for the polyphonic step selector: widths, types, control structs and step tables.
package pss_pkg;

    localparam int CHANNELS = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int STEP_W   = 4;
    localparam int STEPS_W  = CHANNELS * STEP_W;
    localparam int LUT_N    = 256;

    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_HOLD
    } t_sweep_state;

    typedef struct packed {
        logic [CHANNELS-1:0] clk_edge;
        logic [CHANNELS-1:0] rst_edge;
        t_count              nclk;
        t_count              nrst;
        t_count              nsrc;
        t_count              active;
        logic                mclk;
        logic                mrst;
    } t_sweep_cmd;

    typedef struct packed {
        logic [STEPS_W-1:0]  steps;
        logic [CHANNELS-1:0] eoc;
        t_count              active;
    } t_sweep_res;

    typedef logic [LUT_N-1:0][STEP_W-1:0] t_mod_lut;

    // Entry {n-1, s} holds (s + 1) mod n.
    function automatic t_mod_lut f_build_mod_lut();
        t_mod_lut lut;
        int       v;
        lut = '0;
        for (int n = 1; n <= 16; n++) begin
            for (int s = 0; s < 16; s++) begin
                v = s + 1;
                for (int k = 0; k < 17; k++) begin
                    if (v >= n) begin
                        v = v - n;
                    end
                end
                lut[(n - 1) * 16 + s] = STEP_W'(v);
            end
        end
        return lut;
    endfunction

    localparam t_mod_lut MOD_LUT = f_build_mod_lut();

    function automatic t_count f_sat(t_count v);
        return (v > t_count'(CHANNELS)) ? t_count'(CHANNELS) : v;
    endfunction

    function automatic t_idx f_feed(t_idx idx, t_count cnt);
        t_count last;
        last = cnt - 1'b1;
        if (cnt == '0) begin
            return '0;
        end
        if ({1'b0, idx} < last) begin
            return idx;
        end
        return last[IDX_W-1:0];
    endfunction

endpackage

### src/pss_in_if.sv
// Input channel of the step selector: valid, ready and one tick of trigger and count data.
interface pss_in_if import pss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHANNELS-1:0] clock_high_bits;
    logic [CHANNELS-1:0] clock_low_bits;
    logic [CHANNELS-1:0] reset_high_bits;
    logic [CHANNELS-1:0] reset_low_bits;
    t_count              clock_channel_count;
    t_count              reset_channel_count;
    t_count              source_channel_count;
    logic                manual_clock;
    logic                manual_reset;

    modport source (
        output valid, clock_high_bits, clock_low_bits, reset_high_bits, reset_low_bits,
               clock_channel_count, reset_channel_count, source_channel_count,
               manual_clock, manual_reset,
        input  ready
    );

    modport sink (
        input  valid, clock_high_bits, clock_low_bits, reset_high_bits, reset_low_bits,
               clock_channel_count, reset_channel_count, source_channel_count,
               manual_clock, manual_reset,
        output ready
    );
endinterface

### src/pss_out_if.sv
// Output channel of the step selector: valid, ready and one result transaction.
interface pss_out_if import pss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STEPS_W-1:0]  step_indices;
    logic [CHANNELS-1:0] eoc_bits;
    t_count              active_channels;

    modport source (
        output valid, step_indices, eoc_bits, active_channels,
        input  ready
    );

    modport sink (
        input  valid, step_indices, eoc_bits, active_channels,
        output ready
    );
endinterface

### src/pss_cfg_if.sv
// Configuration write channel of the step selector: valid, ready and the channel setting.
interface pss_cfg_if import pss_pkg::*; ();
    logic   valid;
    logic   ready;
    t_count channel_setting;

    modport source (
        output valid, channel_setting,
        input  ready
    );

    modport sink (
        input  valid, channel_setting,
        output ready
    );
endinterface

### src/pss_sweep.sv
// Step memory sweep: read, advance and write back each channel step, one channel per cycle.
module pss_sweep import pss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_sweep_cmd i_cmd,
    output logic       o_idle,
    output logic       o_res_valid,
    input  logic       i_res_take,
    output t_sweep_res o_res
);

    t_step               mem [CHANNELS];
    t_sweep_state        r_state;
    t_sweep_state        n_state;
    t_sweep_cmd          r_cmd;
    t_count              r_rd_idx;
    logic                r_pr_valid;
    t_idx                r_pr_idx;
    t_step               r_mem_q;
    logic [CHANNELS-1:0] r_valid;
    logic [STEPS_W-1:0]  r_steps;
    logic [CHANNELS-1:0] r_eoc;

    logic  w_issue;
    logic  w_last;
    t_idx  w_rd_addr;
    t_step w_cur;
    t_step w_inc;
    t_step w_s1;
    t_step w_s2;
    t_step w_wr_data;
    t_step w_nibble;
    logic  w_eoc;
    logic  w_cedge;
    logic  w_redge;
    logic  w_active;
    t_idx  w_nsrc_m1;

    assign w_rd_addr = r_rd_idx[IDX_W-1:0];
    assign w_last    = r_pr_valid && (r_pr_idx == t_idx'(CHANNELS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (w_last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_idle      = (r_state == S_IDLE);
        o_res_valid = (r_state == S_HOLD);
        w_issue     = (r_state == S_SWEEP) && (r_rd_idx < t_count'(CHANNELS));
    end

    always_comb begin
        w_cur     = r_valid[r_pr_idx] ? r_mem_q : '0;
        w_cedge   = r_cmd.clk_edge[f_feed(r_pr_idx, r_cmd.nclk)];
        w_redge   = r_cmd.rst_edge[f_feed(r_pr_idx, r_cmd.nrst)];
        w_active  = ({1'b0, r_pr_idx} < r_cmd.active);
        w_nsrc_m1 = IDX_W'(r_cmd.nsrc - 1'b1);
        w_inc     = MOD_LUT[{w_nsrc_m1, w_cur}];
        w_s2      = w_cur;
        w_eoc     = 1'b0;
        w_s1      = w_cur;
        if (w_active && (r_cmd.nsrc != '0)) begin
            if (r_cmd.mclk || w_cedge) begin
                w_s1 = w_inc;
            end
            w_s2 = w_s1;
            if (({1'b0, r_pr_idx} < r_cmd.nrst) && r_cmd.rst_edge[r_pr_idx]) begin
                w_s2 = '0;
            end
            w_eoc = (w_cedge || w_redge) && (w_s2 == '0);
        end
        w_nibble  = w_active ? w_s2 : '0;
        w_wr_data = r_cmd.mrst ? '0 : w_s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_idx   <= '0;
            r_pr_valid <= 1'b0;
            r_valid    <= '0;
        end else begin
            r_state    <= n_state;
            r_pr_valid <= w_issue;
            if (i_start && o_idle) begin
                r_rd_idx <= '0;
            end else if (w_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_pr_valid) begin
                r_valid[r_pr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && o_idle) begin
            r_cmd   <= i_cmd;
            r_steps <= '0;
            r_eoc   <= '0;
        end else if (r_pr_valid) begin
            r_steps[r_pr_idx * STEP_W +: STEP_W] <= w_nibble;
            r_eoc[r_pr_idx]                      <= w_eoc;
        end
        if (w_issue) begin
            r_pr_idx <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_mem_q <= mem[w_rd_addr];
        end
        if (r_pr_valid) begin
            mem[r_pr_idx] <= w_wr_data;
        end
    end

    assign o_res.steps  = r_steps;
    assign o_res.eoc    = r_eoc;
    assign o_res.active = r_cmd.active;

endmodule

### src/poly_step_selector.sv
// Top level of the polyphonic step selector: triggers, configuration, sweep and result register.
// Each input transaction is one tick. All clock and reset triggers are evaluated at acceptance;
// the channel steps then live in a 16-entry step memory that is swept one channel per cycle
// (read, advance, write back). The input takes no new transaction until the sweep is through:
// the memory reads, the last write-back, the hand-over to the result register and the return
// to idle, in which the input is ready again. The result register lets a new transaction
// enter while a result still waits on the output; while that register is full and the
// output stalls, the sweep holds its finished result and the input waits.
// Configuration writes are taken at any time and act from the next accepted transaction.
module poly_step_selector import pss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pss_in_if.sink      i_in,
    pss_cfg_if.sink     i_cfg,
    pss_out_if.source   o_out
);

    t_count              r_setting;
    logic [CHANNELS-1:0] r_clk_st;
    logic [CHANNELS-1:0] r_rst_st;
    logic                r_mclk_st;
    logic                r_mrst_st;
    logic                r_out_valid;
    logic [STEPS_W-1:0]  r_out_steps;
    logic [CHANNELS-1:0] r_out_eoc;
    t_count              r_out_active;

    logic       w_in_acc;
    logic       w_idle;
    logic       w_res_valid;
    logic       w_res_take;
    t_sweep_res w_res;
    t_sweep_cmd w_cmd;
    t_count     w_nclk;
    t_count     w_nrst;
    t_count     w_nsrc;
    t_count     w_max;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_idle;
    assign w_in_acc    = i_in.valid && w_idle;
    assign w_res_take  = w_res_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        w_nclk = f_sat(i_in.clock_channel_count);
        w_nrst = f_sat(i_in.reset_channel_count);
        w_nsrc = f_sat(i_in.source_channel_count);
        w_max  = (w_nclk > w_nrst) ? w_nclk : w_nrst;

        w_cmd.clk_edge = ~r_clk_st & i_in.clock_high_bits;
        w_cmd.rst_edge = ~r_rst_st & i_in.reset_high_bits;
        w_cmd.nclk     = w_nclk;
        w_cmd.nrst     = w_nrst;
        w_cmd.nsrc     = w_nsrc;
        w_cmd.mclk     = !r_mclk_st && i_in.manual_clock;
        w_cmd.mrst     = !r_mrst_st && i_in.manual_reset;
        if (r_setting == '0) begin
            w_cmd.active = (w_nclk != '0) ? w_max : t_count'(CHANNELS);
        end else begin
            w_cmd.active = f_sat(r_setting);
        end
    end

    pss_sweep u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_acc),
        .i_cmd       (w_cmd),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting   <= t_count'(CHANNELS);
            r_clk_st    <= '0;
            r_rst_st    <= '0;
            r_mclk_st   <= 1'b0;
            r_mrst_st   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_setting <= i_cfg.channel_setting;
            end
            if (w_in_acc) begin
                r_mclk_st <= i_in.manual_clock;
                r_mrst_st <= i_in.manual_reset;
                if (w_nsrc != '0) begin
                    r_clk_st <= (r_clk_st & ~i_in.clock_low_bits)
                              | (~r_clk_st & i_in.clock_high_bits);
                    r_rst_st <= (r_rst_st & ~i_in.reset_low_bits)
                              | (~r_rst_st & i_in.reset_high_bits);
                end
            end
            if (w_res_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out_steps  <= w_res.steps;
            r_out_eoc    <= w_res.eoc;
            r_out_active <= w_res.active;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.step_indices    = r_out_steps;
    assign o_out.eoc_bits        = r_out_eoc;
    assign o_out.active_channels = r_out_active;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !w_idle)
        else $error("sweep stayed idle after an accepted transaction");

    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_active != '0) && (r_out_active <= t_count'(CHANNELS)))
        else $error("active channel count out of range");

    a_eoc_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_eoc >> r_out_active) == '0))
        else $error("end-of-cycle bit set on an inactive channel");

    a_steps_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_steps >> (r_out_active * STEP_W)) == '0))
        else $error("step reported on an inactive channel");

endmodule

### verif/pss_result_checker.sv
// Watches the step selector channels, predicts each tick's result and compares it with the output.
module pss_result_checker import pss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pss_in_if    i_tick,
    pss_cfg_if   i_cfg,
    pss_out_if   i_res,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_checked
);

    t_step               step_mem [CHANNELS];
    logic [CHANNELS-1:0] clk_trig_q;
    logic [CHANNELS-1:0] rst_trig_q;
    logic                man_clk_q;
    logic                man_rst_q;
    t_count              setting_q;
    t_sweep_res          pending_results [$];
    t_sweep_res          want;
    t_sweep_res          got;
    int                  fails;
    int                  checked;

    function automatic int clamp_count(t_count v);
        return (v > t_count'(CHANNELS)) ? CHANNELS : int'(v);
    endfunction

    function automatic int feeding_channel(int i, int cnt);
        if (cnt == 0) begin
            return 0;
        end
        return (i < cnt - 1) ? i : cnt - 1;
    endfunction

    // {next state, rising edge}
    function automatic logic [1:0] schmitt(logic st, logic hi, logic lo);
        if (st) begin
            return {~lo, 1'b0};
        end
        return hi ? 2'b11 : 2'b00;
    endfunction

    task automatic advance_tick(output t_sweep_res res);
        int                  nclk;
        int                  nrst;
        int                  nsrc;
        int                  active;
        int                  fc;
        int                  fr;
        logic [1:0]          tr;
        logic                mclk;
        logic                mrst;
        logic                ev;
        logic [CHANNELS-1:0] clk_edge;
        logic [CHANNELS-1:0] rst_edge;
        logic [CHANNELS-1:0] eoc;
        logic [STEPS_W-1:0]  steps;

        nclk     = clamp_count(i_tick.clock_channel_count);
        nrst     = clamp_count(i_tick.reset_channel_count);
        nsrc     = clamp_count(i_tick.source_channel_count);
        clk_edge = '0;
        rst_edge = '0;
        eoc      = '0;
        steps    = '0;

        tr        = schmitt(man_clk_q, i_tick.manual_clock, ~i_tick.manual_clock);
        man_clk_q = tr[1];
        mclk      = tr[0];
        tr        = schmitt(man_rst_q, i_tick.manual_reset, ~i_tick.manual_reset);
        man_rst_q = tr[1];
        mrst      = tr[0];

        if (setting_q == '0) begin
            active = (nclk > 0) ? ((nclk > nrst) ? nclk : nrst) : CHANNELS;
        end else begin
            active = clamp_count(setting_q);
        end

        if (nsrc > 0) begin
            for (int i = 0; i < CHANNELS; i++) begin
                tr            = schmitt(clk_trig_q[i], i_tick.clock_high_bits[i],
                                        i_tick.clock_low_bits[i]);
                clk_trig_q[i] = tr[1];
                clk_edge[i]   = tr[0];
                tr            = schmitt(rst_trig_q[i], i_tick.reset_high_bits[i],
                                        i_tick.reset_low_bits[i]);
                rst_trig_q[i] = tr[1];
                rst_edge[i]   = tr[0];
            end
            for (int i = 0; i < active; i++) begin
                fc = feeding_channel(i, nclk);
                fr = feeding_channel(i, nrst);
                ev = clk_edge[fc] | rst_edge[fr];
                if (mclk || clk_edge[fc]) begin
                    step_mem[i] = t_step'((int'(step_mem[i]) + 1) % nsrc);
                end
                if (i < nrst && rst_edge[i]) begin
                    step_mem[i] = '0;
                end
                if (ev && step_mem[i] == '0) begin
                    eoc[i] = 1'b1;
                end
            end
        end

        for (int i = 0; i < active; i++) begin
            steps[STEP_W*i +: STEP_W] = step_mem[i];
        end

        if (mrst) begin
            for (int i = 0; i < CHANNELS; i++) begin
                step_mem[i] = '0;
            end
        end

        res.steps  = steps;
        res.eoc    = eoc;
        res.active = t_count'(active);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                step_mem[i] = '0;
            end
            clk_trig_q = '0;
            rst_trig_q = '0;
            man_clk_q  = 1'b0;
            man_rst_q  = 1'b0;
            setting_q  = t_count'(CHANNELS);
            pending_results.delete();
            fails      = 0;
            checked    = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.steps  = i_res.step_indices;
                got.eoc    = i_res.eoc_bits;
                got.active = i_res.active_channels;
                if (pending_results.size() == 0) begin
                    $error("result transaction with no tick waiting: steps %h eoc %h active %0d",
                           got.steps, got.eoc, got.active);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    checked++;
                    if (got.steps !== want.steps) begin
                        $error("step_indices expected %h actual %h", want.steps, got.steps);
                        fails++;
                    end
                    if (got.eoc !== want.eoc) begin
                        $error("eoc_bits expected %h actual %h", want.eoc, got.eoc);
                        fails++;
                    end
                    if (got.active !== want.active) begin
                        $error("active_channels expected %0d actual %0d", want.active,
                               got.active);
                        fails++;
                    end
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                advance_tick(want);
                pending_results.push_back(want);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                setting_q = i_cfg.channel_setting;
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= pending_results.size();
        o_checked     <= checked;
    end

endmodule

### verif/tb_poly_step_selector.sv
// Testbench top for the step selector: clock, reset, stimulus, output stalls and verdict.
module tb_poly_step_selector import pss_pkg::*; ();

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_TICKS = 65;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   checked;
    int   ticks_sent;
    int   settings_written;

    logic [CHANNELS-1:0] clk_level;
    logic [CHANNELS-1:0] rst_level;
    logic                man_clk_level;
    logic                man_rst_level;

    pss_in_if  tick_if ();
    pss_cfg_if cfg_if ();
    pss_out_if res_if ();

    poly_step_selector dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (tick_if),
        .i_cfg   (cfg_if),
        .o_out   (res_if)
    );

    pss_result_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_tick        (tick_if),
        .i_cfg         (cfg_if),
        .i_res         (res_if),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_count random_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            return t_count'($urandom_range(17, 31));
        end
        if (r < 4) begin
            return '0;
        end
        return t_count'($urandom_range(1, 16));
    endfunction

    task automatic send_tick(input logic [CHANNELS-1:0] chi, clo, rhi, rlo,
                             input t_count nclk, nrst, nsrc, input logic mclk, mrst);
        int gap;
        @(negedge clk);
        tick_if.valid                <= 1'b1;
        tick_if.clock_high_bits      <= chi;
        tick_if.clock_low_bits       <= clo;
        tick_if.reset_high_bits      <= rhi;
        tick_if.reset_low_bits       <= rlo;
        tick_if.clock_channel_count  <= nclk;
        tick_if.reset_channel_count  <= nrst;
        tick_if.source_channel_count <= nsrc;
        tick_if.manual_clock         <= mclk;
        tick_if.manual_reset         <= mrst;
        @(posedge clk);
        while (!tick_if.ready) @(posedge clk);
        ticks_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk) tick_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic random_tick();
        logic [CHANNELS-1:0] chi;
        logic [CHANNELS-1:0] clo;
        logic [CHANNELS-1:0] rhi;
        logic [CHANNELS-1:0] rlo;
        t_count              nsrc;
        int                  r;
        if ($urandom_range(0, 99) < 85) begin
            clk_level = clk_level ^ CHANNELS'($urandom & $urandom);
            if ($urandom_range(0, 3) == 0) begin
                rst_level = rst_level ^ CHANNELS'($urandom & $urandom & $urandom);
            end
            chi = clk_level;
            clo = ~clk_level;
            rhi = rst_level;
            rlo = ~rst_level;
        end else begin
            chi = CHANNELS'($urandom);
            clo = CHANNELS'($urandom);
            rhi = CHANNELS'($urandom);
            rlo = CHANNELS'($urandom);
        end
        r = $urandom_range(0, 11);
        if (r == 0) begin
            nsrc = '0;
        end else if (r == 1) begin
            nsrc = t_count'($urandom_range(17, 31));
        end else begin
            nsrc = t_count'($urandom_range(1, 16));
        end
        if ($urandom_range(0, 5) == 0) begin
            man_clk_level = ~man_clk_level;
        end
        if ($urandom_range(0, 9) == 0) begin
            man_rst_level = ~man_rst_level;
        end
        send_tick(chi, clo, rhi, rlo, random_count(), random_count(), nsrc,
                  man_clk_level, man_rst_level);
    endtask

    task automatic drain();
        @(negedge clk) tick_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_setting(input t_count value);
        @(negedge clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.channel_setting <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk) cfg_if.valid <= 1'b0;
        settings_written++;
    endtask

    // output side: random stalls, stretches of steady acceptance, one long hold-off
    initial begin
        int run;
        int stall;
        bit held;
        held         = 1'b0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            @(negedge clk) res_if.ready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            if (!held && checked >= 150) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                @(negedge clk) res_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding", cycles,
                         outstanding);
                $display("[poly_step_selector] ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_count plan [10];
        plan = '{5'd0, 5'd1, 5'd16, 5'd7, 5'd31, 5'd10, 5'd0, 5'd17, 5'd5, 5'd16};

        rst_n                        = 1'b0;
        tick_if.valid                = 1'b0;
        tick_if.clock_high_bits      = '0;
        tick_if.clock_low_bits       = '0;
        tick_if.reset_high_bits      = '0;
        tick_if.reset_low_bits       = '0;
        tick_if.clock_channel_count  = '0;
        tick_if.reset_channel_count  = '0;
        tick_if.source_channel_count = '0;
        tick_if.manual_clock         = 1'b0;
        tick_if.manual_reset         = 1'b0;
        cfg_if.valid                 = 1'b0;
        cfg_if.channel_setting       = '0;
        clk_level                    = '0;
        rst_level                    = '0;
        man_clk_level                = 1'b0;
        man_rst_level                = 1'b0;
        ticks_sent                   = 0;
        settings_written             = 0;

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        send_tick('0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
        send_tick('1, '0, '0, '0, 5'd16, 5'd16, 5'd16, 1'b0, 1'b0);
        send_tick('0, '1, '0, '1, 5'd16, 5'd16, 5'd16, 1'b0, 1'b0);
        send_tick('1, '0, '1, '0, 5'd16, 5'd16, 5'd16, 1'b0, 1'b0);
        send_tick('0, '1, '0, '1, 5'd16, 5'd16, 5'd16, 1'b0, 1'b0);
        send_tick('0, '1, '0, '1, 5'd16, 5'd16, 5'd3, 1'b1, 1'b0);
        send_tick('0, '1, '0, '1, 5'd16, 5'd16, 5'd3, 1'b0, 1'b0);
        send_tick('1, '0, '0, '1, 5'd16, 5'd16, 5'd9, 1'b1, 1'b1);
        send_tick('0, '1, '0, '1, 5'd16, 5'd16, 5'd9, 1'b0, 1'b0);
        send_tick('1, '0, '1, '0, 5'd16, 5'd16, 5'd0, 1'b1, 1'b0);
        send_tick('1, '0, '0, '1, 5'd31, 5'd31, 5'd31, 1'b0, 1'b0);
        send_tick('0, '1, '0, '1, 5'd31, 5'd31, 5'd31, 1'b0, 1'b0);
        send_tick(16'h0001, 16'hfffe, '0, '1, 5'd0, 5'd0, 5'd4, 1'b0, 1'b0);
        send_tick(16'h0007, 16'hfff8, '0, '1, 5'd3, 5'd2, 5'd4, 1'b0, 1'b0);
        send_tick('0, '1, 16'h0003, 16'hfffc, 5'd3, 5'd2, 5'd4, 1'b0, 1'b0);
        send_tick('1, '1, '1, '1, 5'd16, 5'd16, 5'd16, 1'b0, 1'b0);
        send_tick('0, '0, '0, '0, 5'd16, 5'd16, 5'd16, 1'b0, 1'b0);
        send_tick('0, '1, '0, '1, 5'd8, 5'd4, 5'd5, 1'b0, 1'b0);
        send_tick('1, '0, 16'h00ff, 16'hff00, 5'd8, 5'd4, 5'd5, 1'b0, 1'b0);
        send_tick('0, '1, '0, '1, 5'd16, 5'd16, 5'd1, 1'b0, 1'b0);
        send_tick('1, '0, '0, '1, 5'd16, 5'd16, 5'd1, 1'b0, 1'b0);
        send_tick(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 5'd16, 5'd16, 5'd16, 1'b0, 1'b0);
        drain();

        foreach (plan[p]) begin
            write_setting(plan[p]);
            repeat (PHASE_TICKS) random_tick();
            drain();
        end

        $display("ticks sent: %0d, results checked: %0d, channel settings written: %0d",
                 ticks_sent, checked, settings_written);
        $display("mismatches reported: %0d", fail_count);
        if (fail_count == 0) begin
            $display("[poly_step_selector] OK");
        end else begin
            $display("[poly_step_selector] ERROR");
        end
        $finish;
    end

endmodule
